FILE: hdl/wdm_pkg.sv
// ----------------------------------------------------------------------------
// wdm_pkg: shared types and constants for the waveshaper distortion mix core
// Field widths, register indexes, shape modes, datapath commands and the
// CORDIC arctangent table in Q0.32 turns.
// ----------------------------------------------------------------------------
package wdm_pkg;

  // sample and sine-fold sizing
  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_HARMONICS = 20;
  localparam int HARM_W        = $clog2(MAX_HARMONICS + 1);

  // CORDIC
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 46;  // x/y lanes, wide enough for the soft clip vector
  localparam int ZW           = 34;  // angle lane, Q0.32 turns plus headroom
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;

  // internal datapath widths
  localparam int DRY_W = 16;                // dry sample, Q.15
  localparam int X_W   = 22;                // gained sample
  localparam int Y_W   = 24;                // shaped sample
  localparam int ARG_W = Y_W + HARM_W;      // i*y
  localparam int ACC_W = 44;                // mix accumulator
  localparam int OUT_W = 24;

  // configuration fields
  localparam int DIST_W     = 17;
  localparam int WET_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int HC_W       = 5;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HARM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;  // unused, passes through

  typedef struct packed {
    logic [DIST_W-1:0] dist_amt;
    logic [WET_W-1:0]  wet;
    logic [GAIN_W-1:0] gain;
    logic [HC_W-1:0]   harm;
    logic [MODE_W-1:0] mode;
  } wdm_cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAIN,
    OP_SHAPE,
    OP_SIN_MUL,
    OP_SIN_PHASE,
    OP_ROT_LOAD,
    OP_VEC_LOAD,
    OP_STEP,
    OP_SIN_ACC,
    OP_SOFT_DONE,
    OP_MIX_WET,
    OP_MIX_OUT
  } wdm_op_e;

  typedef struct packed {
    wdm_op_e           op;
    logic [HARM_W-1:0] harm;
    logic [STEP_W-1:0] step;
  } wdm_cmd_t;

  typedef struct packed {
    logic fold_ok;    // sine fold threshold met
    logic soft_zero;  // soft clip input vector is zero
  } wdm_stat_t;

  // atan(2^-k) in Q0.32 turns
  function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] k);
    logic [ZW-1:0] a;
    case (k)
      5'd0:    a = 34'h020000000;
      5'd1:    a = 34'h012E4051E;
      5'd2:    a = 34'h009FB385B;
      5'd3:    a = 34'h0051111D4;
      5'd4:    a = 34'h0028B0D43;
      5'd5:    a = 34'h00145D7E1;
      5'd6:    a = 34'h000A2F61E;
      5'd7:    a = 34'h0005170DB;
      5'd8:    a = 34'h00028BE53;
      5'd9:    a = 34'h000145F2F;
      5'd10:   a = 34'h0000A2F98;
      5'd11:   a = 34'h0000517CC;
      5'd12:   a = 34'h000028BE6;
      5'd13:   a = 34'h0000145F3;
      5'd14:   a = 34'h00000A2FA;
      5'd15:   a = 34'h00000517D;
      5'd16:   a = 34'h0000028BE;
      5'd17:   a = 34'h00000145F;
      5'd18:   a = 34'h000000A30;
      5'd19:   a = 34'h000000518;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/wdm_ctrl.sv
// ----------------------------------------------------------------------------
// wdm_ctrl: sequencer for the waveshaper distortion mix core
// Walks one sample through gain, shaping, CORDIC iterations and mix, and
// owns the input/output handshakes.
// ----------------------------------------------------------------------------
module wdm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  wdm_pkg::wdm_cfg_t  cfg_i,
  input  wdm_pkg::wdm_stat_t stat_i,
  output wdm_pkg::wdm_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_SHAPE,
    S_SIN_MUL,
    S_SIN_PHASE,
    S_ROT_LOAD,
    S_VEC_LOAD,
    S_CORDIC,
    S_SIN_ACC,
    S_SOFT_DONE,
    S_MIX_WET,
    S_MIX_OUT
  } state_e;

  state_e                          state_q;
  logic [wdm_pkg::HARM_W-1:0]      harm_q;
  logic [wdm_pkg::STEP_W-1:0]      step_q;
  logic                            rot_q;
  logic                            out_valid_q;
  logic [wdm_pkg::HARM_W-1:0]      harm_lim;
  logic                            out_free;
  logic                            accept;

  // harmonic count saturates at the supported maximum
  always_comb begin
    if (32'(cfg_i.harm) > wdm_pkg::MAX_HARMONICS) begin
      harm_lim = wdm_pkg::HARM_W'(wdm_pkg::MAX_HARMONICS);
    end else begin
      harm_lim = wdm_pkg::HARM_W'(cfg_i.harm);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o.harm = harm_q;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE:      cmd_o.op = accept ? wdm_pkg::OP_LOAD : wdm_pkg::OP_NONE;
      S_GAIN:      cmd_o.op = wdm_pkg::OP_GAIN;
      S_SHAPE:     cmd_o.op = wdm_pkg::OP_SHAPE;
      S_SIN_MUL:   cmd_o.op = wdm_pkg::OP_SIN_MUL;
      S_SIN_PHASE: cmd_o.op = wdm_pkg::OP_SIN_PHASE;
      S_ROT_LOAD:  cmd_o.op = wdm_pkg::OP_ROT_LOAD;
      S_VEC_LOAD:  cmd_o.op = wdm_pkg::OP_VEC_LOAD;
      S_CORDIC:    cmd_o.op = wdm_pkg::OP_STEP;
      S_SIN_ACC:   cmd_o.op = wdm_pkg::OP_SIN_ACC;
      S_SOFT_DONE: cmd_o.op = wdm_pkg::OP_SOFT_DONE;
      S_MIX_WET:   cmd_o.op = wdm_pkg::OP_MIX_WET;
      S_MIX_OUT:   cmd_o.op = out_free ? wdm_pkg::OP_MIX_OUT : wdm_pkg::OP_NONE;
      default:     cmd_o.op = wdm_pkg::OP_NONE;
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      harm_q      <= '0;
      step_q      <= '0;
      rot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_MIX_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_GAIN;
        end
        S_GAIN: state_q <= S_SHAPE;
        S_SHAPE: begin
          harm_q <= wdm_pkg::HARM_W'(1);
          if (cfg_i.mode == wdm_pkg::MODE_SINE && stat_i.fold_ok && harm_lim != '0) begin
            state_q <= S_SIN_MUL;
          end else if (cfg_i.mode == wdm_pkg::MODE_SOFT && !stat_i.soft_zero) begin
            state_q <= S_VEC_LOAD;
          end else begin
            state_q <= S_MIX_WET;
          end
        end
        S_SIN_MUL:   state_q <= S_SIN_PHASE;
        S_SIN_PHASE: state_q <= S_ROT_LOAD;
        S_ROT_LOAD: begin
          step_q  <= '0;
          rot_q   <= 1'b1;
          state_q <= S_CORDIC;
        end
        S_VEC_LOAD: begin
          step_q  <= '0;
          rot_q   <= 1'b0;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (step_q == wdm_pkg::STEP_W'(wdm_pkg::CORDIC_STEPS - 1)) begin
            state_q <= rot_q ? S_SIN_ACC : S_SOFT_DONE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_SIN_ACC: begin
          if (harm_q == harm_lim) begin
            state_q <= S_MIX_WET;
          end else begin
            harm_q  <= harm_q + 1'b1;
            state_q <= S_SIN_MUL;
          end
        end
        S_SOFT_DONE: state_q <= S_MIX_WET;
        S_MIX_WET:   state_q <= S_MIX_OUT;
        S_MIX_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/wdm_dp.sv
// ----------------------------------------------------------------------------
// wdm_dp: datapath of the waveshaper distortion mix core
// Gain multiply, shaper decisions, one shared CORDIC stage (rotation for the
// sine fold, vectoring for the soft clip) and the two-step wet/dry mix.
// ----------------------------------------------------------------------------
module wdm_dp (
  input  logic                                clk_i,
  input  logic signed [wdm_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  wdm_pkg::wdm_cfg_t                   cfg_i,
  input  wdm_pkg::wdm_cmd_t                   cmd_i,
  output wdm_pkg::wdm_stat_t                  stat_o,
  output logic signed [wdm_pkg::OUT_W-1:0]    sample_out_o
);

  localparam int CW = wdm_pkg::CW;
  localparam int ZW = wdm_pkg::ZW;
  localparam int PROD_W = wdm_pkg::ARG_W + 31;
  localparam logic signed [ZW-1:0] QTR_TURN  = ZW'(64'd1 << 30);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'd1 << 31);
  localparam logic signed [CW-1:0] RND15_C   = CW'(16384);
  localparam logic signed [ZW-1:0] RND15_Z   = ZW'(16384);
  localparam logic signed [CW-1:0] ONE_C     = CW'(32768);
  localparam logic signed [ZW-1:0] ONE_Z     = ZW'(32768);
  localparam logic signed [wdm_pkg::ACC_W-1:0] RND16 = wdm_pkg::ACC_W'(32768);

  logic signed [wdm_pkg::DRY_W-1:0] dry_q;
  logic signed [wdm_pkg::X_W-1:0]   x_q;
  logic signed [wdm_pkg::Y_W-1:0]   y_q;
  logic signed [wdm_pkg::ARG_W-1:0] arg_q;
  logic [31:0]                      ph_q;
  logic signed [CW-1:0]             cx_q, cy_q;
  logic signed [ZW-1:0]             z_q;
  logic                             rot_q;
  logic signed [wdm_pkg::ACC_W-1:0] acc_q;
  logic signed [wdm_pkg::OUT_W-1:0] out_q;

  logic signed [wdm_pkg::SAMPLE_BITS+15:0] s_ext;
  logic signed [wdm_pkg::DRY_W-1:0]   dry_d;
  logic signed [32:0]                 gain_p;
  logic [wdm_pkg::X_W-1:0]            mag;
  logic [wdm_pkg::X_W+6:0]            mag100;
  logic signed [wdm_pkg::X_W+3:0]     x8;
  logic signed [wdm_pkg::DIST_W:0]    sq_thr;
  logic signed [wdm_pkg::X_W+2:0]     mag2;
  logic signed [wdm_pkg::DIST_W:0]    fold_thr;
  logic signed [wdm_pkg::Y_W-1:0]     shape_y;
  logic signed [PROD_W-1:0]           ph_p;
  logic signed [ZW-1:0]               t_fold;
  logic [23:0]                        dist100;
  logic [CW-2:0]                      soft_p;
  logic signed [CW-1:0]               soft_a;
  logic signed [CW-1:0]               dx, dy;
  logic                               up;
  logic [ZW-1:0]                      atan_k;
  logic signed [CW-1:0]               sin_r;
  logic signed [ZW-1:0]               soft_r;
  logic signed [wdm_pkg::ACC_W-1:0]   wet_p;
  logic signed [wdm_pkg::WET_W:0]     dry_w;
  logic signed [wdm_pkg::ACC_W-1:0]   mix_sum;

  // bring the input to Q.15 (floor when wider, zero fill when narrower)
  assign s_ext = {sample_in_i, 16'b0};
  assign dry_d = s_ext[wdm_pkg::SAMPLE_BITS+15 -: wdm_pkg::DRY_W];

  // shaper decisions on the gained sample
  always_comb begin
    gain_p   = dry_q * $signed({1'b0, cfg_i.gain});
    mag      = x_q[wdm_pkg::X_W-1] ? wdm_pkg::X_W'(-x_q) : wdm_pkg::X_W'(x_q);
    mag100   = mag * 7'd100;
    x8       = (wdm_pkg::X_W+4)'(x_q) <<< 3;
    sq_thr   = $signed({1'b0, cfg_i.dist_amt}) - 18'sd32768;
    mag2     = $signed({2'b0, mag, 1'b0});
    fold_thr = 18'sd65536 - $signed({1'b0, cfg_i.dist_amt});
    dist100  = cfg_i.dist_amt * 7'd100;
    soft_p   = dist100 * mag;
    soft_a   = $signed({1'b0, soft_p});

    shape_y = wdm_pkg::Y_W'(x_q);
    case (cfg_i.mode)
      wdm_pkg::MODE_SQUARE: begin
        if (mag100 >= 29'd32768) begin
          shape_y = (x8 >= sq_thr) ? 24'sd32768 : -24'sd32768;
        end
      end
      wdm_pkg::MODE_SOFT: shape_y = '0;
      default:            shape_y = wdm_pkg::Y_W'(x_q);
    endcase
  end

  assign stat_o.fold_ok   = (mag2 >= fold_thr);
  assign stat_o.soft_zero = (mag == '0) || (cfg_i.dist_amt == '0);

  // sine phase in turns and fold to a quarter turn either side
  always_comb begin
    ph_p   = arg_q * $signed({1'b0, wdm_pkg::INV_TWO_PI_Q32});
    t_fold = ZW'($signed(ph_q));
    if (t_fold > QTR_TURN) begin
      t_fold = HALF_TURN - t_fold;
    end else if (t_fold < -QTR_TURN) begin
      t_fold = -HALF_TURN - t_fold;
    end
  end

  // one CORDIC micro-rotation
  always_comb begin
    dx     = cy_q >>> cmd_i.step;
    dy     = cx_q >>> cmd_i.step;
    up     = rot_q ? ~z_q[ZW-1] : cy_q[CW-1];
    atan_k = wdm_pkg::atan_turn(cmd_i.step);
  end

  // CORDIC results rounded to Q.15 and clamped
  always_comb begin
    sin_r = (cy_q + RND15_C) >>> 15;
    if (sin_r > ONE_C) sin_r = ONE_C;
    if (sin_r < -ONE_C) sin_r = -ONE_C;
    soft_r = (z_q + RND15_Z) >>> 15;
    if (soft_r > ONE_Z) soft_r = ONE_Z;
    if (soft_r < 0) soft_r = '0;
    if (x_q[wdm_pkg::X_W-1]) soft_r = -soft_r;
  end

  // wet/dry mix
  always_comb begin
    wet_p   = y_q * $signed({1'b0, cfg_i.wet});
    dry_w   = 18'sd65536 - $signed({1'b0, cfg_i.wet});
    mix_sum = acc_q + dry_q * dry_w + RND16;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wdm_pkg::OP_LOAD:      dry_q <= dry_d;
      wdm_pkg::OP_GAIN:      x_q <= wdm_pkg::X_W'((gain_p + 33'sd2048) >>> 12);
      wdm_pkg::OP_SHAPE:     y_q <= shape_y;
      wdm_pkg::OP_SIN_MUL:   arg_q <= $signed({1'b0, cmd_i.harm}) * y_q;
      wdm_pkg::OP_SIN_PHASE: ph_q <= ph_p[46:15];
      wdm_pkg::OP_ROT_LOAD: begin
        cx_q  <= CW'($signed({1'b0, wdm_pkg::CORDIC_GAIN_Q30}));
        cy_q  <= '0;
        z_q   <= t_fold;
        rot_q <= 1'b1;
      end
      wdm_pkg::OP_VEC_LOAD: begin
        cx_q  <= CW'(64'd1 << 31);
        cy_q  <= soft_a;
        z_q   <= '0;
        rot_q <= 1'b0;
      end
      wdm_pkg::OP_STEP: begin
        if (up) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - $signed(atan_k);
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + $signed(atan_k);
        end
      end
      wdm_pkg::OP_SIN_ACC:   y_q <= y_q + sin_r[wdm_pkg::Y_W-1:0];
      wdm_pkg::OP_SOFT_DONE: y_q <= soft_r[wdm_pkg::Y_W-1:0];
      wdm_pkg::OP_MIX_WET:   acc_q <= wet_p;
      wdm_pkg::OP_MIX_OUT:   out_q <= mix_sum[16 +: wdm_pkg::OUT_W];
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

FILE: hdl/waveshaper_distortion_mix_core.sv
// ----------------------------------------------------------------------------
// waveshaper_distortion_mix_core: gain, waveshaper and wet/dry mix
// Configuration registers, sequencer and datapath for one audio sample at a
// time: square, sine fold or soft clip shaping, output in Q9.15.
// ----------------------------------------------------------------------------
// One sample word is in flight at a time. Sine fold runs one term per
// harmonic (up to 20), each term taking two multiply steps, one load, 20
// CORDIC iterations and one accumulate. The single shared CORDIC stage
// runs one iteration per cycle. A new word is taken while the previous
// result still waits at the output. Registers must be written only while
// the core is idle; the core itself does not enforce this.
module waveshaper_distortion_mix_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wdm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [wdm_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [wdm_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [wdm_pkg::OUT_W-1:0]       sample_out_o
);

  wdm_pkg::wdm_cfg_t  cfg_q;
  wdm_pkg::wdm_cmd_t  cmd;
  wdm_pkg::wdm_stat_t stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_amt <= 17'd32768;
      cfg_q.wet      <= 17'd32768;
      cfg_q.gain     <= 16'd4096;
      cfg_q.harm     <= 5'd1;
      cfg_q.mode     <= wdm_pkg::MODE_SQUARE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wdm_pkg::REG_DIST: cfg_q.dist_amt <= cfg_data_i[wdm_pkg::DIST_W-1:0];
        wdm_pkg::REG_WET:  cfg_q.wet      <= cfg_data_i[wdm_pkg::WET_W-1:0];
        wdm_pkg::REG_GAIN: cfg_q.gain     <= cfg_data_i[wdm_pkg::GAIN_W-1:0];
        wdm_pkg::REG_HARM: cfg_q.harm     <= cfg_data_i[wdm_pkg::HC_W-1:0];
        wdm_pkg::REG_MODE: cfg_q.mode     <= cfg_data_i[wdm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  wdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_i       (cfg_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wdm_dp u_dp (
    .clk_i        (clk_i),
    .sample_in_i  (sample_in_i),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_out_o (sample_out_o)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the waveshaper distortion mix core
// Drives audio sample words through the valid/ready input, compares every
// output word with a bit-exact software predictor of gain, shaping and mix,
// and steps through register settings between phases, extremes included.
// ----------------------------------------------------------------------------

// Expected-output tracker: holds the register copy and predicts each word
class mix_scoreboard;
  logic [wdm_pkg::DIST_W-1:0] dist_amt;
  logic [wdm_pkg::WET_W-1:0]  wet;
  logic [wdm_pkg::GAIN_W-1:0] gain;
  logic [wdm_pkg::HC_W-1:0]   harm;
  logic [wdm_pkg::MODE_W-1:0] mode;
  logic [23:0]                expected_q[$];
  longint                     atan_tab[20];
  int                         errors;

  function new();
    atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                 64'h0145D7E1, 64'h00A2F61E, 64'h005170DB, 64'h0028BE53, 64'h00145F2F,
                 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
                 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518};
    dist_amt = 17'd32768;
    wet      = 17'd32768;
    gain     = 16'd4096;
    harm     = 5'd1;
    mode     = wdm_pkg::MODE_SQUARE;
    errors   = 0;
  endfunction

  function void write_reg(logic [wdm_pkg::CFG_IDX_W-1:0] idx,
                          logic [wdm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      wdm_pkg::REG_DIST: dist_amt = data;
      wdm_pkg::REG_WET:  wet      = data;
      wdm_pkg::REG_GAIN: gain     = data[15:0];
      wdm_pkg::REG_HARM: harm     = data[4:0];
      wdm_pkg::REG_MODE: mode     = data[1:0];
      default: ;
    endcase
  endfunction

  // sine of a Q.15 radian argument via rotation CORDIC on the phase in turns
  function longint sine_q15(longint arg);
    longint unsigned prod;
    longint t, cx, cy, dx, dy, r;
    prod = $unsigned(arg) * 64'd683565276;
    t    = longint'((prod >> 15) & 64'hFFFF_FFFF);
    cx   = 652032874;
    cy   = 0;
    if (t >= (64'sd1 <<< 31)) t = t - (64'sd1 <<< 32);
    if (t > (64'sd1 <<< 30)) t = (64'sd1 <<< 31) - t;
    else if (t < -(64'sd1 <<< 30)) t = -(64'sd1 <<< 31) - t;
    for (int k = 0; k < 20; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (t >= 0) begin
        cx -= dx; cy += dy; t -= atan_tab[k];
      end else begin
        cx += dx; cy -= dy; t += atan_tab[k];
      end
    end
    r = (cy + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // (2/pi)*atan(100*amount*x) via vectoring CORDIC, angle in turns
  function longint soft_clip_q15(longint x);
    longint mag, cx, cy, z, dx, dy, r;
    mag = (x < 0) ? -x : x;
    cy  = 100 * longint'(dist_amt) * mag;
    cx  = 64'sd1 <<< 31;
    z   = 0;
    if (cy == 0) return 0;
    for (int k = 0; k < 20; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += atan_tab[k];
      end else begin
        cx -= dx; cy += dy; z -= atan_tab[k];
      end
    end
    r = (z + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < 0) r = 0;
    return (x < 0) ? -r : r;
  endfunction

  function logic [23:0] mixed_sample(logic signed [15:0] smp);
    longint dry, x, y, mag, acc;
    int     n;
    dry = smp;
    x   = (dry * longint'(gain) + 2048) >>> 12;
    y   = x;
    mag = (x < 0) ? -x : x;
    case (mode)
      wdm_pkg::MODE_SQUARE: begin
        if (100 * mag >= 32768)
          y = (8 * x >= longint'(dist_amt) - 32768) ? 32768 : -32768;
      end
      wdm_pkg::MODE_SINE: begin
        if (2 * mag >= 65536 - longint'(dist_amt)) begin
          n = (harm > 20) ? 20 : harm;
          for (int i = 1; i <= n; i++) y += sine_q15(i * y);
        end
      end
      wdm_pkg::MODE_SOFT: y = soft_clip_q15(x);
      default: ;
    endcase
    acc = y * longint'(wet) + dry * (65536 - longint'(wet));
    return 24'((acc + 32768) >>> 16);
  endfunction

  function void note_sample(logic signed [15:0] smp);
    expected_q.push_back(mixed_sample(smp));
  endfunction

  function void check_word(logic [23:0] got);
    logic [23:0] want;
    if (expected_q.size() == 0) begin
      $error("sample_out: unexpected word, actual %0d", $signed(got));
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEMS_PER_SET = 90;
  // index outside the register map
  localparam logic [wdm_pkg::CFG_IDX_W-1:0] REG_STRAY = 3'd6;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   cfg_we_i = 1'b0;
  logic [wdm_pkg::CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [wdm_pkg::CFG_DATA_W-1:0]         cfg_data_i = '0;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_ready_o;
  logic signed [wdm_pkg::SAMPLE_BITS-1:0] sample_in_i = '0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic signed [wdm_pkg::OUT_W-1:0]       sample_out_o;

  mix_scoreboard sb = new();
  bit            idle_on = 1'b1;
  int            words_out = 0;
  int            quiet_cycles = 0;

  waveshaper_distortion_mix_core dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // output side: random ready gaps, one long hold-off to back up the input
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (words_out == 60) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(sample_out_o);
      words_out++;
    end
  end

  task automatic send_word(logic signed [15:0] smp);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(smp);
  endtask

  task automatic write_reg(logic [wdm_pkg::CFG_IDX_W-1:0] idx,
                           logic [wdm_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // wait for the core to drain, then load a full register set
  task automatic load_setting(int d, int w, int g, int h, int m);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(wdm_pkg::REG_DIST, wdm_pkg::CFG_DATA_W'(d));
    write_reg(wdm_pkg::REG_WET, wdm_pkg::CFG_DATA_W'(w));
    write_reg(wdm_pkg::REG_GAIN, wdm_pkg::CFG_DATA_W'(g));
    write_reg(wdm_pkg::REG_HARM, wdm_pkg::CFG_DATA_W'(h));
    write_reg(wdm_pkg::REG_MODE, wdm_pkg::CFG_DATA_W'(m));
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      1: return 16'($signed($urandom_range(0, 800)) - 400);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(int count);
    repeat (count) send_word(pick_sample());
  endtask

  initial begin
    logic signed [15:0] edge_words[$] = '{-32768, 32767, 0, 1, -1, 327, 328, -327, -328,
                                          16384, -16384, 4096, -4096, 2000, -20000,
                                          32000, 12345, -1000, 100, -100};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: directed extremes, then random words
    foreach (edge_words[i]) send_word(edge_words[i]);
    run_random(ITEMS_PER_SET);

    load_setting(0, 65536, 4096, 1, wdm_pkg::MODE_SQUARE);
    run_random(ITEMS_PER_SET);
    idle_on = 1'b0;
    load_setting(65536, 0, 40960, 0, wdm_pkg::MODE_SQUARE);
    run_random(ITEMS_PER_SET);
    idle_on = 1'b1;
    load_setting(32768, 65536, 4096, 1, wdm_pkg::MODE_SINE);
    run_random(ITEMS_PER_SET);
    load_setting(65536, 65536, 40960, 20, wdm_pkg::MODE_SINE);
    run_random(ITEMS_PER_SET);
    load_setting(0, 65536, 4096, 3, wdm_pkg::MODE_SINE);
    run_random(ITEMS_PER_SET);
    idle_on = 1'b0;
    load_setting(40000, 50000, 8192, 31, wdm_pkg::MODE_SINE);
    run_random(ITEMS_PER_SET);
    idle_on = 1'b1;
    load_setting(1, 65536, 4096, 0, wdm_pkg::MODE_SOFT);
    run_random(ITEMS_PER_SET);
    load_setting(65536, 65536, 40960, 0, wdm_pkg::MODE_SOFT);
    run_random(ITEMS_PER_SET);
    load_setting(0, 65536, 4096, 0, wdm_pkg::MODE_SOFT);
    run_random(ITEMS_PER_SET);
    // unused mode and out-of-range registers; a stray index must be ignored
    load_setting(131071, 131071, 65535, 7, wdm_pkg::MODE_SPARE);
    write_reg(REG_STRAY, 17'h1FFFF);
    run_random(ITEMS_PER_SET);
    load_setting(131071, 131071, 65535, 0, wdm_pkg::MODE_SQUARE);
    run_random(ITEMS_PER_SET);

    // random register sets across the full field widths
    for (int p = 0; p < 4; p++) begin
      idle_on = (p != 2);
      load_setting($urandom_range(0, 131071), $urandom_range(0, 131071),
                   $urandom_range(0, 65535), $urandom_range(0, 31), $urandom_range(0, 3));
      run_random(ITEMS_PER_SET);
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
